// ===== rtl/tlga_pkg.sv =====
package tlga_pkg;

  localparam int unsigned ROWS        = 16;
  localparam int unsigned LUT_ENTRIES = 16;

  localparam int unsigned IdxW    = 4;
  localparam int unsigned LutW    = 8;
  localparam int unsigned AccW    = 20;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned ScaledW = 52;
  localparam int unsigned NibW    = 64;

  localparam logic [IdxW-1:0] NibbleMask = 4'hF;
  localparam logic [IdxW-1:0] LastRow    = IdxW'(ROWS - 1);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_WEIGHT = 1'b1
  } tlga_op_e;

  typedef struct packed {
    tlga_op_e                operation;
    logic [IdxW-1:0]         lut_index;
    logic signed [LutW-1:0]  lut_value;
    logic [NibW-1:0]         weight_nibbles;
    logic                    last_group;
  } tlga_in_t;

  typedef struct packed {
    logic [IdxW-1:0]           row_index;
    logic signed [AccW-1:0]    row_sum;
    logic signed [ScaledW-1:0] scaled_sum;
    logic                      last;
  } tlga_out_t;

  // accumulator plus table entry, clamped to the accumulator range
  function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] acc,
                                                    logic signed [LutW-1:0] v);
    logic signed [AccW:0] s;
    s = {acc[AccW-1], acc} + (AccW+1)'(v);
    if (s > (AccW+1)'(AccMax)) begin
      return AccMax;
    end else if (s < (AccW+1)'(AccMin)) begin
      return AccMin;
    end
    return s[AccW-1:0];
  endfunction

endpackage

// ===== rtl/tlga_if.sv =====
interface tlga_in_if
  import tlga_pkg::*;
;
  logic     valid;
  logic     ready;
  tlga_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlga_out_if
  import tlga_pkg::*;
;
  logic      valid;
  logic      ready;
  tlga_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ternary_lut_gemv_accumulator_unit.sv =====
// Ternary lookup-table matrix-vector accumulator for a block of 16 rows. A load word
// writes one signed entry of the 16-entry table; a weight word does all sixteen lookups
// and saturating adds in the cycle it is accepted, so the input takes one word per cycle
// unless a last-group word waits. A weight word marked last_group copies the finished sums
// into a result buffer and clears the accumulators; the buffer then drains one row per
// cycle through the scale multiplier into the output register while the output is not
// stalled. Load and weight words keep flowing during the drain; only the next last-group
// word waits; it is taken in the cycle the last row of the prior block leaves the buffer.
module ternary_lut_gemv_accumulator_unit
  import tlga_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ScaleW-1:0] cfg_wdata_i,
  tlga_in_if.sink           in_i,
  tlga_out_if.source        out_o
);

  logic [ScaleW-1:0]      scale_q;
  logic signed [LutW-1:0] lut_q [LUT_ENTRIES];
  logic signed [AccW-1:0] acc_q [ROWS];
  logic signed [AccW-1:0] acc_sum [ROWS];
  logic signed [AccW-1:0] snap_q [ROWS];

  logic            busy_q, busy_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            out_valid_q;
  tlga_out_t       out_q, out_d;

  logic in_fire, wt_fire, last_fire, out_load, drain_fire, drain_done;

  logic signed [AccW+ScaleW:0] product;

  assign out_load   = !out_valid_q || out_o.ready;
  assign drain_fire = busy_q && out_load;
  assign drain_done = drain_fire && (cnt_q == LastRow);

  // a last-group word needs the result buffer free, other words never wait
  assign in_i.ready = !(in_i.data.operation == OP_WEIGHT && in_i.data.last_group &&
                        busy_q && !drain_done);

  assign in_fire   = in_i.valid && in_i.ready;
  assign wt_fire   = in_fire && in_i.data.operation == OP_WEIGHT;
  assign last_fire = wt_fire && in_i.data.last_group;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      acc_sum[r] = sat_add(acc_q[r], lut_q[in_i.data.weight_nibbles[IdxW*r +: IdxW] &
                                           NibbleMask]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LUT_ENTRIES; i++) begin
        lut_q[i] <= '0;
      end
    end else if (in_fire && in_i.data.operation == OP_LOAD) begin
      lut_q[in_i.data.lut_index] <= in_i.data.lut_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        acc_q[r] <= '0;
      end
    end else if (wt_fire) begin
      for (int r = 0; r < ROWS; r++) begin
        acc_q[r] <= in_i.data.last_group ? '0 : acc_sum[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_fire) begin
      for (int r = 0; r < ROWS; r++) begin
        snap_q[r] <= acc_sum[r];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (drain_fire) begin
      cnt_d = cnt_q + 1'b1;
      if (drain_done) begin
        busy_d = 1'b0;
      end
    end
    if (last_fire) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // signed sum times unsigned scale, exact
  assign product = snap_q[cnt_q[IdxW-1:0]] * $signed({1'b0, scale_q});

  always_comb begin
    out_d.row_index  = cnt_q;
    out_d.row_sum    = snap_q[cnt_q[IdxW-1:0]];
    out_d.scaled_sum = product[ScaledW-1:0];
    out_d.last       = (cnt_q == LastRow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |=> busy_q && cnt_q == '0)
    else $error("result buffer not armed after last group");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |=> acc_q[0] == '0 && acc_q[ROWS-1] == '0)
    else $error("accumulators not cleared after last group");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last |-> out_q.row_index == LastRow)
    else $error("last flag on wrong row");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |-> !busy_q || drain_done)
    else $error("last group taken while buffer still draining");

endmodule
